/* hdl/tcw_pkg.sv */
// Package for the text console writer: sequencer states, operation codes,
// character codes, configuration register indexes and the cursor action type.
// No dependencies.
`default_nettype none

package tcw_pkg;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_RDATA,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_FILL
  } state_t;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  localparam logic [1:0] CFG_FORE = 2'd0;
  localparam logic [1:0] CFG_BACK = 2'd1;

  localparam logic [3:0] FORE_RESET  = 4'hF;
  localparam logic [3:0] BACK_RESET  = 4'h0;
  localparam logic [7:0] RESET_COLOR = 8'h0F;

  typedef struct packed {
    logic wr;
    logic scroll;
  } cur_act_t;

endpackage

`default_nettype wire

/* hdl/text_console_writer.sv */
// Top level of the text console writer: sequencer, cursor and color registers,
// configuration port and result register. Depends on tcw_pkg, tcw_ram and
// tcw_cursor.
`default_nettype none

// A text console of ROWS x COLS cells with a cursor. After reset the block
// blanks the whole store and holds busy high meanwhile; configuration
// writes are taken at any time. An item is taken when start is high and busy
// is low; its result appears on the out_ ports for one cycle with out_strobe
// and cannot be stalled. A character with no scroll, an ignored op and an
// out-of-range read end in ST_EXEC; a valid read adds ST_RDATA, a clear adds
// ST_FILL over every cell, and a scrolling character adds a copy of rows
// 1 to ROWS-1 up one row, then ST_FILL of the bottom row: the store has one
// write and one read port, so each copied cell takes ST_SCR_RD then ST_SCR_WR.
module text_console_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_op,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [4:0]  in_read_row,
  input  wire logic [6:0]  in_read_col,
  output logic             out_strobe,
  output logic      [15:0] out_cell_value,
  output logic      [4:0]  out_cur_row,
  output logic      [6:0]  out_cur_col,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [3:0]  cfg_wdata
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int COL_W = $clog2(COLS);
  localparam int ROW_W = $clog2(ROWS);

  localparam logic [AW-1:0] COLS_A      = AW'(COLS);
  localparam logic [AW-1:0] BOT_A       = AW'((ROWS - 1) * COLS);
  localparam logic [AW-1:0] LAST_COPY_A = AW'((ROWS - 1) * COLS - 1);
  localparam logic [AW-1:0] LAST_A      = AW'(CELLS - 1);

  tcw_pkg::state_t   state_r, state_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [3:0]        fore_r;
  logic [3:0]        back_r;
  tcw_pkg::op_t      op_r;
  logic [7:0]        ch_r;
  logic [4:0]        rr_r;
  logic [6:0]        rc_r;
  logic              strobe_r, strobe_nxt;
  logic [15:0]       cell_r, cell_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [15:0]       ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [15:0]       ram_rdata;

  tcw_pkg::cur_act_t act;
  logic [COL_W-1:0]  wcol;
  logic [7:0]        wchar;
  logic [ROW_W-1:0]  nrow;
  logic [COL_W-1:0]  ncol;

  logic [AW-1:0]     sel_row;
  logic [AW-1:0]     sel_col;
  logic [AW-1:0]     cell_addr;
  logic              rd_in_range;
  logic [15:0]       blank_cell;

  tcw_ram #(
    .DEPTH (CELLS),
    .WIDTH (16)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tcw_cursor #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_cursor (
    .ch    (ch_r),
    .row   (row_r),
    .col   (col_r),
    .act   (act),
    .wcol  (wcol),
    .wchar (wchar),
    .nrow  (nrow),
    .ncol  (ncol)
  );

  assign busy           = (state_r != tcw_pkg::ST_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_strobe     = strobe_r;
  assign out_cell_value = cell_r;
  assign out_cur_row    = 5'(row_r);
  assign out_cur_col    = 7'(col_r);
  assign blank_cell     = {back_r, fore_r, tcw_pkg::CH_SPACE};
  assign rd_in_range    = (32'(rr_r) < ROWS) && (32'(rc_r) < COLS);

  always_comb begin
    if (op_r == tcw_pkg::OP_READ) begin
      sel_row = AW'(rr_r);
      sel_col = AW'(rc_r);
    end else begin
      sel_row = AW'(row_r);
      sel_col = AW'(wcol);
    end
    cell_addr = sel_row * COLS_A + sel_col;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcw_pkg::ST_INIT: begin
        if (ptr_r == LAST_A) begin
          state_nxt = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = tcw_pkg::ST_EXEC;
        end
      end
      tcw_pkg::ST_EXEC: begin
        case (op_r)
          tcw_pkg::OP_PUT: begin
            state_nxt = act.scroll ? tcw_pkg::ST_SCR_RD : tcw_pkg::ST_IDLE;
          end
          tcw_pkg::OP_CLEAR: begin
            state_nxt = tcw_pkg::ST_FILL;
          end
          tcw_pkg::OP_READ: begin
            state_nxt = rd_in_range ? tcw_pkg::ST_RDATA : tcw_pkg::ST_IDLE;
          end
          default: begin
            state_nxt = tcw_pkg::ST_IDLE;
          end
        endcase
      end
      tcw_pkg::ST_RDATA: begin
        state_nxt = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_SCR_RD: begin
        state_nxt = tcw_pkg::ST_SCR_WR;
      end
      tcw_pkg::ST_SCR_WR: begin
        state_nxt = (ptr_r == LAST_COPY_A) ? tcw_pkg::ST_FILL : tcw_pkg::ST_SCR_RD;
      end
      tcw_pkg::ST_FILL: begin
        if (ptr_r == LAST_A) begin
          state_nxt = tcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ptr_nxt    = ptr_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    strobe_nxt = 1'b0;
    cell_nxt   = cell_r;
    ram_we     = 1'b0;
    ram_waddr  = ptr_r;
    ram_wdata  = blank_cell;
    ram_raddr  = cell_addr;
    case (state_r)
      tcw_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = {tcw_pkg::RESET_COLOR, tcw_pkg::CH_SPACE};
        ptr_nxt   = ptr_r + AW'(1);
      end
      tcw_pkg::ST_EXEC: begin
        ptr_nxt = '0;
        case (op_r)
          tcw_pkg::OP_PUT: begin
            ram_we    = act.wr;
            ram_waddr = cell_addr;
            ram_wdata = {back_r, fore_r, wchar};
            row_nxt   = nrow;
            col_nxt   = ncol;
            if (!act.scroll) begin
              strobe_nxt = 1'b1;
              cell_nxt   = '0;
            end
          end
          tcw_pkg::OP_CLEAR: begin
            row_nxt = '0;
            col_nxt = '0;
          end
          tcw_pkg::OP_READ: begin
            if (!rd_in_range) begin
              strobe_nxt = 1'b1;
              cell_nxt   = '0;
            end
          end
          default: begin
            strobe_nxt = 1'b1;
            cell_nxt   = '0;
          end
        endcase
      end
      tcw_pkg::ST_RDATA: begin
        strobe_nxt = 1'b1;
        cell_nxt   = ram_rdata;
      end
      tcw_pkg::ST_SCR_RD: begin
        ram_raddr = ptr_r + COLS_A;
      end
      tcw_pkg::ST_SCR_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        ptr_nxt   = (ptr_r == LAST_COPY_A) ? BOT_A : ptr_r + AW'(1);
      end
      tcw_pkg::ST_FILL: begin
        ram_we  = 1'b1;
        ptr_nxt = ptr_r + AW'(1);
        if (ptr_r == LAST_A) begin
          strobe_nxt = 1'b1;
          cell_nxt   = '0;
        end
      end
      default: begin
        ptr_nxt = ptr_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tcw_pkg::ST_INIT;
      ptr_r    <= '0;
      row_r    <= '0;
      col_r    <= '0;
      strobe_r <= 1'b0;
      fore_r   <= tcw_pkg::FORE_RESET;
      back_r   <= tcw_pkg::BACK_RESET;
    end else begin
      state_r  <= state_nxt;
      ptr_r    <= ptr_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tcw_pkg::CFG_FORE: fore_r <= cfg_wdata;
          tcw_pkg::CFG_BACK: back_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
    if (start && !busy) begin
      op_r <= tcw_pkg::op_t'(in_op);
      ch_r <= in_char_code;
      rr_r <= in_read_row;
      rc_r <= in_read_col;
    end
  end

`ifndef NO_ASSERTIONS
  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without preceding work");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not make the block busy");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(row_r) < ROWS) && (32'(col_r) < COLS))
    else $error("cursor outside the screen");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (32'(ram_waddr) < CELLS))
    else $error("cell store write outside the store");
`endif

endmodule

`default_nettype wire

/* hdl/tcw_ram.sv */
// Cell store of the text console writer: one write port and one read port
// with registered read data. Depends on nothing.
`default_nettype none

module tcw_ram #(
  parameter int DEPTH = 2000,
  parameter int WIDTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/tcw_cursor.sv */
// Cursor step unit: decodes one character and gives the cell to write,
// the next cursor position and whether the store must scroll.
// Depends on tcw_pkg.
`default_nettype none

module tcw_cursor #(
  parameter int COLS = 80,
  parameter int ROWS = 25,
  localparam int COL_W = $clog2(COLS),
  localparam int ROW_W = $clog2(ROWS)
) (
  input  wire logic [7:0]       ch,
  input  wire logic [ROW_W-1:0] row,
  input  wire logic [COL_W-1:0] col,
  output tcw_pkg::cur_act_t     act,
  output logic      [COL_W-1:0] wcol,
  output logic      [7:0]       wchar,
  output logic      [ROW_W-1:0] nrow,
  output logic      [COL_W-1:0] ncol
);

  localparam logic [COL_W:0] COLS_X   = (COL_W+1)'(COLS);
  localparam logic [ROW_W:0] ROWS_X   = (ROW_W+1)'(ROWS);
  localparam logic [COL_W:0] TAB_MASK = ~((COL_W+1)'(3));

  logic [COL_W:0] col_x;
  logic [COL_W:0] col_inc;
  logic [COL_W:0] col_tab;
  logic [ROW_W:0] row_inc;
  logic           nl;

  always_comb begin
    col_x   = {1'b0, col};
    col_inc = col_x + (COL_W+1)'(1);
    col_tab = (col_x + (COL_W+1)'(4)) & TAB_MASK;
    row_inc = {1'b0, row} + (ROW_W+1)'(1);
    act     = '0;
    wcol    = col;
    wchar   = ch;
    ncol    = col;
    nrow    = row;
    nl      = 1'b0;
    case (ch)
      tcw_pkg::CH_NEWLINE: begin
        nl = 1'b1;
      end
      tcw_pkg::CH_RETURN: begin
        ncol = '0;
      end
      tcw_pkg::CH_TAB: begin
        if (col_tab >= COLS_X) begin
          nl = 1'b1;
        end else begin
          ncol = col_tab[COL_W-1:0];
        end
      end
      tcw_pkg::CH_BACKSPACE: begin
        if (col != '0) begin
          ncol   = col - COL_W'(1);
          wcol   = col - COL_W'(1);
          wchar  = tcw_pkg::CH_SPACE;
          act.wr = 1'b1;
        end
      end
      default: begin
        act.wr = 1'b1;
        if (col_inc >= COLS_X) begin
          nl = 1'b1;
        end else begin
          ncol = col_inc[COL_W-1:0];
        end
      end
    endcase
    if (nl) begin
      ncol = '0;
      if (row_inc >= ROWS_X) begin
        act.scroll = 1'b1;
        nrow       = ROW_W'(ROWS - 1);
      end else begin
        nrow = row_inc[ROW_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

/* tb/text_console_writer_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for text_console_writer: drives put, clear, read and ignored words
// plus color register writes, and checks each result against a shadow copy of the screen.
// Depends on tcw_pkg and the text_console_writer RTL.
module text_console_writer_test;

  localparam int SCREEN_COLS     = 80;
  localparam int SCREEN_ROWS     = 25;
  localparam int SCREEN_CELLS    = SCREEN_COLS * SCREEN_ROWS;
  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int TAIL_CYCLES     = 8;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 215;

  typedef struct packed {
    logic [15:0] cell_val;
    logic [4:0]  row;
    logic [6:0]  col;
  } console_reply_t;

  class screen_tracker;
    logic [15:0]    cells [SCREEN_CELLS];
    int unsigned    row;
    int unsigned    col;
    logic [3:0]     fore;
    logic [3:0]     back;
    console_reply_t awaited [$];
    int             errors;
    int             checked;
    int             reads;
    int             clears;
    int             scrolls;

    function new();
      fore = tcw_pkg::FORE_RESET;
      back = tcw_pkg::BACK_RESET;
      blank_screen();
      row = 0;
      col = 0;
    endfunction

    function logic [15:0] glyph(logic [7:0] ch);
      return {back, fore, ch};
    endfunction

    function void blank_screen();
      for (int i = 0; i < SCREEN_CELLS; i++) cells[i] = glyph(tcw_pkg::CH_SPACE);
    endfunction

    function void set_register(logic [1:0] idx, logic [3:0] data);
      if (idx == tcw_pkg::CFG_FORE) fore = data;
      else if (idx == tcw_pkg::CFG_BACK) back = data;
    endfunction

    function void line_feed();
      col = 0;
      row++;
      if (row >= SCREEN_ROWS) begin
        for (int i = 0; i < (SCREEN_ROWS - 1) * SCREEN_COLS; i++)
          cells[i] = cells[i + SCREEN_COLS];
        for (int i = (SCREEN_ROWS - 1) * SCREEN_COLS; i < SCREEN_CELLS; i++)
          cells[i] = glyph(tcw_pkg::CH_SPACE);
        row = SCREEN_ROWS - 1;
        scrolls++;
      end
    endfunction

    function void put_byte(logic [7:0] ch);
      case (ch)
        tcw_pkg::CH_NEWLINE: line_feed();
        tcw_pkg::CH_RETURN: col = 0;
        tcw_pkg::CH_TAB: begin
          col = (col + 4) & ~32'd3;
          if (col >= SCREEN_COLS) line_feed();
        end
        tcw_pkg::CH_BACKSPACE: begin
          if (col > 0) begin
            col--;
            cells[row * SCREEN_COLS + col] = glyph(tcw_pkg::CH_SPACE);
          end
        end
        default: begin
          cells[row * SCREEN_COLS + col] = glyph(ch);
          col++;
          if (col >= SCREEN_COLS) line_feed();
        end
      endcase
    endfunction

    function void apply_item(tcw_pkg::op_t op, logic [7:0] ch, logic [4:0] rr,
                             logic [6:0] rc);
      console_reply_t reply;
      reply.cell_val = '0;
      case (op)
        tcw_pkg::OP_PUT: put_byte(ch);
        tcw_pkg::OP_CLEAR: begin
          blank_screen();
          row = 0;
          col = 0;
          clears++;
        end
        tcw_pkg::OP_READ: begin
          reads++;
          if (rr < SCREEN_ROWS && rc < SCREEN_COLS)
            reply.cell_val = cells[rr * SCREEN_COLS + rc];
        end
        default: ;
      endcase
      reply.row = 5'(row);
      reply.col = 7'(col);
      awaited.push_back(reply);
    endfunction

    function void compare_result(logic [15:0] cell_val, logic [4:0] r, logic [6:0] c);
      console_reply_t want;
      if (awaited.size() == 0) begin
        $error("result word with no item pending: cell %h row %0d col %0d", cell_val, r, c);
        errors++;
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (cell_val !== want.cell_val) begin
        $error("cell_value: expected %h, got %h", want.cell_val, cell_val);
        errors++;
      end
      if (r !== want.row) begin
        $error("cur_row: expected %0d, got %0d", want.row, r);
        errors++;
      end
      if (c !== want.col) begin
        $error("cur_col: expected %0d, got %0d", want.col, c);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_op = tcw_pkg::OP_PUT;
  logic [7:0]  in_char_code = '0;
  logic [4:0]  in_read_row = '0;
  logic [6:0]  in_read_col = '0;
  logic        out_strobe;
  logic [15:0] out_cell_value;
  logic [4:0]  out_cur_row;
  logic [6:0]  out_cur_col;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [3:0]  cfg_wdata = '0;

  screen_tracker tracker;
  bit            idling = 1'b1;
  int            items_sent = 0;
  int            color_writes = 0;
  int            stall_cycles = 0;

  text_console_writer #(
    .COLS(SCREEN_COLS),
    .ROWS(SCREEN_ROWS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_op(in_op),
    .in_char_code(in_char_code),
    .in_read_row(in_read_row),
    .in_read_col(in_read_col),
    .out_strobe(out_strobe),
    .out_cell_value(out_cell_value),
    .out_cur_row(out_cur_row),
    .out_cur_col(out_cur_col),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      tracker.compare_result(out_cell_value, out_cur_row, out_cur_col);
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [7:0] control_byte();
    case ($urandom_range(0, 3))
      0: return tcw_pkg::CH_NEWLINE;
      1: return tcw_pkg::CH_RETURN;
      2: return tcw_pkg::CH_TAB;
      default: return tcw_pkg::CH_BACKSPACE;
    endcase
  endfunction

  task automatic send_item(input tcw_pkg::op_t op, input logic [7:0] ch,
                           input logic [4:0] rr, input logic [6:0] rc);
    @(negedge clk);
    start <= 1'b1;
    in_op <= op;
    in_char_code <= ch;
    in_read_row <= rr;
    in_read_col <= rc;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.apply_item(op, ch, rr, rc);
    items_sent++;
    if (idling && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(1, 16) - 1) @(negedge clk);
    end
  endtask

  task automatic send_read();
    int         mode;
    logic [4:0] rr;
    logic [6:0] rc;
    mode = $urandom_range(0, 9);
    if (mode < 5) begin
      rr = 5'(tracker.row);
      rc = 7'($urandom_range(0, SCREEN_COLS - 1));
    end else if (mode < 8) begin
      rr = 5'($urandom_range(0, SCREEN_ROWS - 1));
      rc = 7'($urandom_range(0, SCREEN_COLS - 1));
    end else begin
      rr = 5'($urandom);
      rc = 7'($urandom);
    end
    send_item(tcw_pkg::OP_READ, 8'($urandom), rr, rc);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (tracker.awaited.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [3:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_register(idx, data);
    color_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int budget, input bit allow_idle);
    int         done;
    int         kind;
    int         len;
    logic [7:0] ch;
    done = 0;
    while (done < budget) begin
      kind = $urandom_range(0, 99);
      idling = allow_idle && ($urandom_range(0, 3) != 0);
      if (kind < 40) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 24);
        for (int k = 0; k < len; k++) begin
          ch = ($urandom_range(0, 19) == 0) ? control_byte() : 8'($urandom_range(0, 255));
          send_item(tcw_pkg::OP_PUT, ch, 5'($urandom), 7'($urandom));
        end
        done += len;
      end else if (kind < 60) begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++)
          send_item(tcw_pkg::OP_PUT, control_byte(), 5'($urandom), 7'($urandom));
        done += len;
      end else if (kind < 85) begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) send_read();
        done += len;
      end else if (kind < 89) begin
        send_item(tcw_pkg::OP_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
        done += 1;
      end else if (kind < 94) begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++)
          send_item(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE, 5'($urandom), 7'($urandom));
        done += len;
      end else begin
        len = $urandom_range(1, 3);
        for (int k = 0; k < len; k++)
          send_item(tcw_pkg::OP_NONE, 8'($urandom), 5'($urandom), 7'($urandom));
      end
    end
  endtask

  initial begin
    logic [3:0] fore_plan [PHASES];
    logic [3:0] back_plan [PHASES];
    tracker = new();
    fore_plan = '{4'h0, 4'hF, 4'h0, 4'($urandom), 4'($urandom), tcw_pkg::FORE_RESET};
    back_plan = '{4'h0, 4'hF, 4'hF, 4'($urandom), 4'($urandom), tcw_pkg::BACK_RESET};
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    drain();

    send_item(tcw_pkg::OP_READ, 8'h00, 5'd0, 7'd0);
    send_item(tcw_pkg::OP_READ, 8'hFF, 5'd24, 7'd79);
    send_item(tcw_pkg::OP_READ, 8'h00, 5'd31, 7'd127);
    send_item(tcw_pkg::OP_READ, 8'h00, 5'd0, 7'd80);
    send_item(tcw_pkg::OP_READ, 8'h00, 5'd25, 7'd0);
    send_item(tcw_pkg::OP_NONE, 8'hA5, 5'h1F, 7'h7F);
    send_item(tcw_pkg::OP_PUT, 8'd65, 5'd0, 7'd0);
    send_item(tcw_pkg::OP_PUT, 8'd0, 5'd0, 7'd0);
    send_item(tcw_pkg::OP_PUT, 8'd255, 5'd0, 7'd0);
    send_item(tcw_pkg::OP_PUT, 8'd128, 5'd0, 7'd0);
    send_item(tcw_pkg::OP_PUT, 8'd127, 5'd0, 7'd0);
    send_item(tcw_pkg::OP_READ, 8'h00, 5'd0, 7'd2);
    send_item(tcw_pkg::OP_READ, 8'h00, 5'd0, 7'd3);
    send_item(tcw_pkg::OP_PUT, tcw_pkg::CH_BACKSPACE, 5'd0, 7'd0);
    send_item(tcw_pkg::OP_READ, 8'h00, 5'd0, 7'd4);
    send_item(tcw_pkg::OP_PUT, tcw_pkg::CH_TAB, 5'd0, 7'd0);
    send_item(tcw_pkg::OP_PUT, tcw_pkg::CH_TAB, 5'd0, 7'd0);
    send_item(tcw_pkg::OP_PUT, tcw_pkg::CH_RETURN, 5'd0, 7'd0);
    send_item(tcw_pkg::OP_PUT, tcw_pkg::CH_BACKSPACE, 5'd0, 7'd0);
    send_item(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE, 5'd0, 7'd0);
    send_item(tcw_pkg::OP_PUT, 8'd120, 5'd0, 7'd0);
    send_item(tcw_pkg::OP_CLEAR, 8'h00, 5'd0, 7'd0);
    send_item(tcw_pkg::OP_READ, 8'h00, 5'd1, 7'd0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_register(tcw_pkg::CFG_FORE, fore_plan[p]);
      write_register(tcw_pkg::CFG_BACK, back_plan[p]);
      run_phase(ITEMS_PER_PHASE, p != PHASES - 1);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d words (%0d reads, %0d clears, %0d scrolls) over %0d color writes.",
             items_sent, tracker.reads, tracker.clears, tracker.scrolls, color_writes);
    $display("Checked %0d result words, %0d mismatches.", tracker.checked, tracker.errors);
    if (tracker.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/tcw_pkg.sv
hdl/tcw_ram.sv
hdl/tcw_cursor.sv
hdl/text_console_writer.sv
tb/text_console_writer_test.sv
